// File: design/mct_pkg.sv
// Shared types and constants for the Markov cohort trace block.
// No dependencies; imported by every module of the block.
`default_nettype none

package mct_pkg;

  // Occupancy word width (Q24.FRAC) and result state index width
  localparam int OCC_W = 40;
  localparam int IDX_W = 5;
  localparam int CFG_W = 5;

  // Request kinds
  typedef enum logic [2:0] {
    KIND_MTX  = 3'd0,
    KIND_OCC  = 3'd1,
    KIND_MORT = 3'd2,
    KIND_ADV  = 3'd3,
    KIND_EMIT = 3'd4
  } kind_e;

  // Configuration register indexes
  localparam logic CFG_MORT_ADJ = 1'b0;
  localparam logic CFG_STATES   = 1'b1;

  // Reset value of the states-in-use register
  localparam logic [CFG_W-1:0] STATES_RST = 5'd16;

  // Control travelling with each multiply-accumulate term
  typedef struct packed {
    logic vld;    // term present
    logic first;  // first term of a column, restarts the sum
    logic last;   // last term of a column, result ready
    logic dead;   // dead-state column: probability is mortality
    logic unit;   // dead-state carry-over term: probability is one
  } mac_ctl_t;

endpackage

`default_nettype wire

// File: design/markov_cohort_trace_step.sv
// Markov cohort trace step: matrix memory, mortality registers, sequencer,
// occupancy store (mct_occ_store) and MAC pipeline (mct_mac); the issue loop sets the rate.
// Advance: issue of every matrix term (plus the dead column with mortality adjust), drain, scratch read,
// then S (+1 dead) results one per cycle; busy falls after the last result is shown.
// Emit: registered store read, then one result per cycle. No result stall.
// Reset (async, active low) zeroes occupancies and mortalities; matrix undefined until written.
`default_nettype none

module markov_cohort_trace_step #(
  parameter int NUM_STATES = 16,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  // Request channel
  input  wire logic                      start_i,
  output logic                           busy_o,
  input  wire logic [2:0]                kind_i,
  input  wire logic [4:0]                row_index_i,
  input  wire logic [3:0]                col_index_i,
  input  wire logic [mct_pkg::OCC_W-1:0] value_i,
  // Configuration write port
  input  wire logic                      cfg_we_i,
  input  wire logic                      cfg_idx_i,
  input  wire logic [mct_pkg::CFG_W-1:0] cfg_wdata_i,
  // Result channel
  output logic                           out_strobe_o,
  output logic [mct_pkg::IDX_W-1:0]      state_index_o,
  output logic [mct_pkg::OCC_W-1:0]      occupancy_o,
  output logic                           last_o
);
  import mct_pkg::*;

  localparam int PW  = FRAC_BITS + 1;
  localparam int SW  = $clog2(NUM_STATES + 2);
  localparam int OAW = $clog2(NUM_STATES + 1);
  localparam int RW  = $clog2(NUM_STATES);
  localparam int MAW = $clog2(NUM_STATES * NUM_STATES);
  localparam logic [PW-1:0]    ONE  = PW'(1) << FRAC_BITS;
  localparam logic [OAW-1:0]   DEAD = OAW'(NUM_STATES);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN,
    ST_COPY,
    ST_EMIT,
    ST_FIN
  } state_e;

  state_e state_q;

  logic             accept;
  logic             adj_q;
  logic [CFG_W-1:0] states_q;
  logic [SW-1:0]    s, s_m1, k_last, n_cols;
  logic [SW-1:0]    i_q, j_q, k_q, wcol_q;
  logic             dead_col, last_i, last_col;
  logic [PW-1:0]    prob_wr;

  logic [PW-1:0]    mtx_mem [NUM_STATES * NUM_STATES];
  logic [PW-1:0]    mtx_rdata_q;
  logic [MAW-1:0]   mtx_raddr, mtx_waddr;
  logic             mtx_we;

  logic [PW-1:0]    mort_q [NUM_STATES];
  logic [PW-1:0]    mort_rd_q;

  logic [OCC_W-1:0] nxt_mem [NUM_STATES + 1];
  logic [OCC_W-1:0] nxt_rdata_q;
  logic [OAW-1:0]   nxt_waddr;

  logic             occ_we;
  logic [OAW-1:0]   occ_waddr, occ_raddr, iss_occ_addr, emit_addr;
  logic [OCC_W-1:0] occ_wdata, occ_rdata;

  mac_ctl_t         iss_ctl_d, iss_ctl_q;
  logic             res_vld;
  logic [OCC_W-1:0] res;

  logic             cp_we_q, src_nxt_q;
  logic [OAW-1:0]   cp_addr_q;
  logic             strobe_q, last_q;
  logic [IDX_W-1:0] idx_q;

  assign busy_o = (state_q != ST_IDLE);
  assign accept = start_i & ~busy_o;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      adj_q    <= 1'b0;
      states_q <= STATES_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MORT_ADJ: adj_q    <= cfg_wdata_i[0];
        CFG_STATES:   states_q <= cfg_wdata_i;
        default:      ;
      endcase
    end
  end

  // Live state count, clamped to 1..NUM_STATES
  always_comb begin
    if (states_q == '0) begin
      s = SW'(1);
    end else if (int'(states_q) > NUM_STATES) begin
      s = SW'(NUM_STATES);
    end else begin
      s = SW'(states_q);
    end
  end

  assign s_m1   = s - SW'(1);
  assign k_last = adj_q ? s : s_m1;
  assign n_cols = s + SW'(adj_q);

  // Probability clipped to one on write
  assign prob_wr = (value_i > OCC_W'(ONE)) ? ONE : value_i[PW-1:0];

  // Transition matrix memory
  assign mtx_we    = accept && (kind_e'(kind_i) == KIND_MTX) &&
                     (int'(row_index_i) < NUM_STATES) && (int'(col_index_i) < NUM_STATES);
  assign mtx_waddr = MAW'(int'(row_index_i) * NUM_STATES + int'(col_index_i));
  assign mtx_raddr = dead_col ? '0 : MAW'(int'(i_q) * NUM_STATES + int'(j_q));

  always_ff @(posedge clk_i) begin
    if (mtx_we) begin
      mtx_mem[mtx_waddr] <= prob_wr;
    end
    mtx_rdata_q <= mtx_mem[mtx_raddr];
  end

  // Mortality probabilities
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < NUM_STATES; r++) begin
        mort_q[r] <= '0;
      end
    end else if (accept && (kind_e'(kind_i) == KIND_MORT) &&
                 (int'(row_index_i) < NUM_STATES)) begin
      mort_q[RW'(row_index_i)] <= prob_wr;
    end
  end

  always_ff @(posedge clk_i) begin
    mort_rd_q <= (int'(i_q) < NUM_STATES) ? mort_q[RW'(i_q)] : '0;
  end

  // Issue control for the current term
  assign dead_col = (j_q == s);
  assign last_i   = dead_col ? (i_q == s) : (i_q == s_m1);
  assign last_col = dead_col || ((j_q == s_m1) && !adj_q);
  assign iss_occ_addr = (dead_col && (i_q == s)) ? DEAD : OAW'(i_q);

  always_comb begin
    iss_ctl_d = '0;
    if (state_q == ST_ISSUE) begin
      iss_ctl_d.vld   = 1'b1;
      iss_ctl_d.first = (i_q == '0);
      iss_ctl_d.last  = last_i;
      iss_ctl_d.dead  = dead_col;
      iss_ctl_d.unit  = dead_col && (i_q == s);
    end
  end

  // Align control with the registered memory read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iss_ctl_q <= '0;
    end else begin
      iss_ctl_q <= iss_ctl_d;
    end
  end

  mct_mac #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mac (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adj_i     (adj_q),
    .ctl_i     (iss_ctl_q),
    .prob_i    (mtx_rdata_q),
    .mort_i    (mort_rd_q),
    .occ_i     (occ_rdata),
    .res_vld_o (res_vld),
    .res_o     (res)
  );

  // Next-occupancy scratch memory, filled column by column
  assign nxt_waddr = (wcol_q == s) ? DEAD : OAW'(wcol_q);
  assign emit_addr = (k_q == s) ? DEAD : OAW'(k_q);

  always_ff @(posedge clk_i) begin
    if (res_vld) begin
      nxt_mem[nxt_waddr] <= res;
    end
    nxt_rdata_q <= nxt_mem[emit_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wcol_q <= '0;
    end else if (accept) begin
      wcol_q <= '0;
    end else if (res_vld) begin
      wcol_q <= wcol_q + SW'(1);
    end
  end

  // Occupancy store: request writes, or copy-back from scratch
  assign occ_we    = cp_we_q ||
                     (accept && (kind_e'(kind_i) == KIND_OCC) &&
                      (int'(row_index_i) <= NUM_STATES));
  assign occ_waddr = cp_we_q ? cp_addr_q : OAW'(row_index_i);
  assign occ_wdata = cp_we_q ? nxt_rdata_q : value_i;
  assign occ_raddr = (state_q == ST_EMIT) ? emit_addr : iss_occ_addr;

  mct_occ_store #(
    .DEPTH (NUM_STATES + 1),
    .AW    (OAW)
  ) u_occ (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (occ_we),
    .waddr_i (occ_waddr),
    .wdata_i (occ_wdata),
    .raddr_i (occ_raddr),
    .rdata_o (occ_rdata)
  );

  // Sequencer with registered result controls
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      i_q       <= '0;
      j_q       <= '0;
      k_q       <= '0;
      cp_we_q   <= 1'b0;
      cp_addr_q <= '0;
      src_nxt_q <= 1'b0;
      strobe_q  <= 1'b0;
      last_q    <= 1'b0;
      idx_q     <= '0;
    end else begin
      strobe_q  <= (state_q == ST_COPY) || (state_q == ST_EMIT);
      cp_we_q   <= (state_q == ST_COPY);
      cp_addr_q <= emit_addr;
      src_nxt_q <= (state_q == ST_COPY);
      last_q    <= (k_q == k_last);
      idx_q     <= IDX_W'(emit_addr);
      unique case (state_q)
        ST_IDLE: begin
          i_q <= '0;
          j_q <= '0;
          k_q <= '0;
          if (accept) begin
            case (kind_e'(kind_i))
              KIND_ADV:  state_q <= ST_ISSUE;
              KIND_EMIT: state_q <= ST_EMIT;
              default:   state_q <= ST_IDLE;
            endcase
          end
        end
        ST_ISSUE: begin
          if (last_i) begin
            i_q <= '0;
            if (last_col) begin
              state_q <= ST_DRAIN;
            end else begin
              j_q <= j_q + SW'(1);
            end
          end else begin
            i_q <= i_q + SW'(1);
          end
        end
        ST_DRAIN: begin
          if (wcol_q == n_cols) begin
            state_q <= ST_COPY;
          end
        end
        ST_COPY, ST_EMIT: begin
          if (k_q == k_last) begin
            state_q <= ST_FIN;
          end else begin
            k_q <= k_q + SW'(1);
          end
        end
        ST_FIN: begin
          state_q <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Result ports
  assign out_strobe_o  = strobe_q;
  assign state_index_o = idx_q;
  assign last_o        = last_q;
  assign occupancy_o   = src_nxt_q ? nxt_rdata_q : occ_rdata;

endmodule

`default_nettype wire

// File: design/mct_occ_store.sv
// Cohort occupancy store: synchronous memory, one write and one read port.
// Entries read as zero until first written. Uses mct_pkg.
`default_nettype none

module mct_occ_store #(
  parameter int DEPTH = 17,
  parameter int AW    = 5
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    we_i,
  input  wire logic [AW-1:0]           waddr_i,
  input  wire logic [mct_pkg::OCC_W-1:0] wdata_i,
  input  wire logic [AW-1:0]           raddr_i,
  output logic [mct_pkg::OCC_W-1:0]    rdata_o
);
  import mct_pkg::*;

  logic [OCC_W-1:0] mem [DEPTH];
  logic [OCC_W-1:0] rdata_q;
  logic [DEPTH-1:0] vld_q;
  logic             rvld_q;

  // Storage array and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  // Written flags, cleared at reset so untouched entries read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (we_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
      rvld_q <= vld_q[raddr_i];
    end
  end

  assign rdata_o = rvld_q ? rdata_q : '0;

endmodule

`default_nettype wire

// File: design/mct_mac.sv
// Multiply-accumulate pipeline: mortality-adjusted probability, scaled
// term, saturating column sum. Three register stages. Uses mct_pkg.
`default_nettype none

module mct_mac #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      adj_i,
  input  wire mct_pkg::mac_ctl_t         ctl_i,
  input  wire logic [FRAC_BITS:0]        prob_i,
  input  wire logic [FRAC_BITS:0]        mort_i,
  input  wire logic [mct_pkg::OCC_W-1:0] occ_i,
  output logic                           res_vld_o,
  output logic [mct_pkg::OCC_W-1:0]      res_o
);
  import mct_pkg::*;

  localparam int PW = FRAC_BITS + 1;
  localparam int QW = 2 * PW;
  localparam int MW = OCC_W + PW;
  localparam logic [PW-1:0] ONE    = PW'(1) << FRAC_BITS;
  localparam logic [QW-1:0] Q_HALF = QW'(1) << (FRAC_BITS - 1);
  localparam logic [MW-1:0] M_HALF = MW'(1) << (FRAC_BITS - 1);

  mac_ctl_t         ctla_q, ctlb_q;
  logic [PW-1:0]    q_d, q_q;
  logic [QW-1:0]    qprod;
  logic [OCC_W-1:0] occa_q;
  logic [MW-1:0]    prod_q;
  logic [OCC_W-1:0] term, acc_d, acc_q;
  logic [OCC_W:0]   sum;

  // Stage A: effective transition probability
  assign qprod = (QW'(ONE - mort_i) * QW'(prob_i)) + Q_HALF;

  always_comb begin
    if (ctl_i.dead) begin
      q_d = ctl_i.unit ? ONE : mort_i;
    end else if (adj_i) begin
      q_d = qprod[FRAC_BITS +: PW];
    end else begin
      q_d = prob_i;
    end
  end

  // Stage B: occupancy times probability, rounding half added
  always_ff @(posedge clk_i) begin
    q_q    <= q_d;
    occa_q <= occ_i;
    prod_q <= (MW'(occa_q) * MW'(q_q)) + M_HALF;
  end

  // Stage C: saturating accumulation over the column
  assign term  = prod_q[FRAC_BITS +: OCC_W];
  assign sum   = {1'b0, acc_q} + {1'b0, term};
  assign acc_d = ctlb_q.first ? term : (sum[OCC_W] ? '1 : sum[OCC_W-1:0]);

  always_ff @(posedge clk_i) begin
    if (ctlb_q.vld) begin
      acc_q <= acc_d;
    end
  end

  // Control alongside the data stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctla_q <= '0;
      ctlb_q <= '0;
    end else begin
      ctla_q <= ctl_i;
      ctlb_q <= ctla_q;
    end
  end

  assign res_vld_o = ctlb_q.vld & ctlb_q.last;
  assign res_o     = acc_d;

endmodule

`default_nettype wire
